@@ rtl/slr_pkg.sv @@
// Package for the spool length to rotation block: field widths, fixed-point
// constants, register indexes and the side data that travels with an item.
// No dependencies.
package slr_pkg;

  localparam int LEN_W    = 20;
  localparam int THICK_W  = 16;
  localparam int RAD_W    = 24;
  localparam int ROT_W    = 32;
  localparam int LEN_UM_W = 30;
  localparam int TL_W     = 46;
  localparam int RR_W     = 48;
  localparam int D_W      = 63;
  localparam int REM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int NUM_W    = 42;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // 1/pi as an unsigned Q0.32 fraction, floor(2^32/pi).
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [9:0]  UM_PER_MM  = 10'd1000;
  localparam logic [9:0]  DEG_SCALE  = 10'd720;

  localparam logic [THICK_W-1:0] THICK_RESET  = 16'd1000;
  localparam logic [RAD_W-1:0]   RADIUS_RESET = 24'd50000;

  localparam logic [CFG_IDX_W-1:0] CFG_THICK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;

  // Front end 4, root ROOT_W, subtract and scale 2, divide NUM_W, output 1.
  localparam int LATENCY = 4 + ROOT_W + 2 + NUM_W + 1;

  typedef struct packed {
    logic [THICK_W-1:0] thick;
    logic [RAD_W-1:0]   radius;
  } slr_side_t;

endpackage

@@ rtl/slr_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on slr_pkg.
module slr_sqrt_pipe (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [slr_pkg::D_W-1:0]  in_d,
  input  slr_pkg::slr_side_t       in_side,
  output logic                     out_valid,
  output logic [slr_pkg::ROOT_W-1:0] out_root,
  output slr_pkg::slr_side_t       out_side
);
  import slr_pkg::*;

  logic                  vld_r  [0:ROOT_W];
  logic [REM_W-1:0]      rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]     root_r [0:ROOT_W];
  slr_side_t             side_r [0:ROOT_W];

  always_comb begin
    vld_r[0]  = in_valid;
    rem_r[0]  = REM_W'(in_d);
    root_r[0] = '0;
    side_r[0] = in_side;
  end

  genvar k;
  generate
    for (k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [REM_W-1:0]  cand;
      logic [REM_W-1:0]  rem_nxt;
      logic [ROOT_W-1:0] root_nxt;

      // Trial subtract of (2*root + 2^B) * 2^B, i.e. (root | 2^B)^2 - root^2.
      always_comb begin
        cand = (REM_W'(root_r[k]) << (B + 1)) + (REM_W'(1) << (2 * B));
        if (rem_r[k] >= cand) begin
          rem_nxt  = rem_r[k] - cand;
          root_nxt = root_r[k] | (ROOT_W'(1) << B);
        end else begin
          rem_nxt  = rem_r[k];
          root_nxt = root_r[k];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else begin
          vld_r[k+1] <= vld_r[k];
        end
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  endgenerate

  assign out_valid = vld_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule

@@ rtl/slr_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on slr_pkg.
module slr_div_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [slr_pkg::NUM_W-1:0]   in_num,
  input  logic [slr_pkg::THICK_W-1:0] in_den,
  output logic                        out_valid,
  output logic [slr_pkg::NUM_W-1:0]   out_quot,
  output logic [slr_pkg::THICK_W-1:0] out_den
);
  import slr_pkg::*;

  logic               vld_r  [0:NUM_W];
  logic [NUM_W-1:0]   num_r  [0:NUM_W];
  logic [NUM_W-1:0]   quot_r [0:NUM_W];
  logic [THICK_W-1:0] rem_r  [0:NUM_W];
  logic [THICK_W-1:0] den_r  [0:NUM_W];

  always_comb begin
    vld_r[0]  = in_valid;
    num_r[0]  = in_num;
    quot_r[0] = '0;
    rem_r[0]  = '0;
    den_r[0]  = in_den;
  end

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_stage
      localparam int B = NUM_W - 1 - k;
      logic [THICK_W:0]   part;
      logic [THICK_W-1:0] rem_nxt;
      logic [NUM_W-1:0]   quot_nxt;

      always_comb begin
        part = {rem_r[k], num_r[k][B]};
        if (part >= {1'b0, den_r[k]}) begin
          rem_nxt  = THICK_W'(part - {1'b0, den_r[k]});
          quot_nxt = quot_r[k] | (NUM_W'(1) << B);
        end else begin
          rem_nxt  = part[THICK_W-1:0];
          quot_nxt = quot_r[k];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else begin
          vld_r[k+1] <= vld_r[k];
        end
        num_r[k+1]  <= num_r[k];
        quot_r[k+1] <= quot_nxt;
        rem_r[k+1]  <= rem_nxt;
        den_r[k+1]  <= den_r[k];
      end
    end
  endgenerate

  assign out_valid = vld_r[NUM_W];
  assign out_quot  = quot_r[NUM_W];
  assign out_den   = den_r[NUM_W];

endmodule

@@ rtl/spool_length_to_rotation.sv @@
// Spool length to rotation: a fully pipelined converter from wound wire length
// to spool rotation. A new item is taken every cycle and busy never rises,
// since the receiver cannot stall.
// The depth is set by the 32-stage square root and the 42-stage divider.
// Synchronous active-low reset clears the pipeline valid bits and restores the
// thickness register to 1000 um and the core radius register to 50000 um.
module spool_length_to_rotation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [slr_pkg::LEN_W-1:0]       in_length_mm,
  output logic                            out_valid,
  output logic [slr_pkg::ROT_W-1:0]       out_rotation_deg_q8,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import slr_pkg::*;

  // Configuration registers. Writes to unknown indexes are dropped.
  logic [THICK_W-1:0] thick_r;
  logic [RAD_W-1:0]   radius_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r  <= THICK_RESET;
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THICK:  thick_r  <= cfg_data[THICK_W-1:0];
        CFG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // The register values travel with each item so every stage sees a
  // consistent set of operands.
  logic              v1_r, v2_r, v3_r, v4_r;
  logic [LEN_UM_W-1:0] len_um_r;
  slr_side_t         side1_r, side2_r, side3_r, side4_r;
  logic [TL_W-1:0]   tl_r;
  logic [RR_W-1:0]   rr2_r, rr3_r;
  logic [62:0]       plo_r;
  logic [44:0]       phi_r;
  logic [D_W-1:0]    d_r;

  // Stage 1 converts millimetres to micrometres.
  // Stage 2 forms t*L and R^2.
  // Stage 3 multiplies t*L by 1/pi as two partial products.
  // Stage 4 assembles the discriminant R^2*2^14 + floor(t*L/pi * 2^14).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    len_um_r       <= LEN_UM_W'(in_length_mm * UM_PER_MM);
    side1_r.thick  <= thick_r;
    side1_r.radius <= radius_r;
    tl_r    <= TL_W'(side1_r.thick * len_um_r);
    rr2_r   <= RR_W'(side1_r.radius * side1_r.radius);
    side2_r <= side1_r;
    plo_r   <= 63'(tl_r[31:0] * INV_PI_Q32);
    phi_r   <= 45'(tl_r[TL_W-1:32] * INV_PI_Q32);
    rr3_r   <= rr2_r;
    side3_r <= side2_r;
    d_r     <= D_W'((D_W'(rr3_r) << 14) + (D_W'(phi_r) << 14) + D_W'(plo_r >> 18));
    side4_r <= side3_r;
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  slr_side_t         sq_side;

  slr_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_d      (d_r),
    .in_side   (side4_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // The root never falls below R*2^7, so the difference is non-negative.
  logic               v5_r, v6_r;
  logic [ROOT_W-1:0]  diff_r;
  logic [THICK_W-1:0] thick5_r, thick6_r;
  logic [NUM_W-1:0]   num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v5_r <= sq_valid;
      v6_r <= v5_r;
    end
    diff_r   <= ROOT_W'(sq_root - ROOT_W'({sq_side.radius, 7'b0}));
    thick5_r <= sq_side.thick;
    num_r    <= NUM_W'(diff_r * DEG_SCALE);
    thick6_r <= thick5_r;
  end

  logic               dv_valid;
  logic [NUM_W-1:0]   dv_quot;
  logic [THICK_W-1:0] dv_den;

  slr_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v6_r),
    .in_num    (num_r),
    .in_den    (thick6_r),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_den   (dv_den)
  );

  // Zero thickness gives zero; a quotient above 32 bits saturates.
  logic             out_valid_r;
  logic [ROT_W-1:0] rot_r, rot_nxt;

  always_comb begin
    if (dv_den == '0) begin
      rot_nxt = '0;
    end else if (dv_quot[NUM_W-1:ROT_W] != '0) begin
      rot_nxt = '1;
    end else begin
      rot_nxt = dv_quot[ROT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
    rot_r <= rot_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_rotation_deg_q8 = rot_r;

endmodule

@@ rtl/slr_checker.sv @@
// Port-level checker for spool_length_to_rotation, bound to the top level.
// Depends on slr_pkg.
module slr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [slr_pkg::LEN_W-1:0]      in_length_mm,
  input logic                           out_valid,
  input logic [slr_pkg::ROT_W-1:0]      out_rotation_deg_q8,
  input logic                           cfg_ready
);
  import slr_pkg::*;

  // Every accepted item yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted item produced no result");

  // No result appears without an item accepted the latency earlier.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching item");

  // A zero length always winds zero rotation.
  a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_length_mm == '0) |-> ##LATENCY (out_rotation_deg_q8 == '0))
    else $error("zero length gave nonzero rotation");

  // The block never refuses an item or a register write.
  a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("block signaled busy");

endmodule

bind spool_length_to_rotation slr_checker u_slr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_length_mm        (in_length_mm),
  .out_valid           (out_valid),
  .out_rotation_deg_q8 (out_rotation_deg_q8),
  .cfg_ready           (cfg_ready)
);

@@ sim/tb_spool_length_to_rotation.sv @@
// Self-checking testbench for spool_length_to_rotation: random and directed lengths
// over several thickness and radius settings, checked against an integer predictor.
// Depends on rtl/slr_pkg.sv and rtl/spool_length_to_rotation.sv.
module tb_spool_length_to_rotation;
  timeunit 1ns;
  timeprecision 1ps;
  import slr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] INV_PI = 64'd1367130551;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [LEN_W-1:0]      in_length_mm = '0;
  logic                  out_valid;
  logic [ROT_W-1:0]      out_rotation_deg_q8;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spool_length_to_rotation uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_length_mm(in_length_mm), .out_valid(out_valid),
    .out_rotation_deg_q8(out_rotation_deg_q8), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copies of the two registers, updated at the edge that writes them.
  logic [THICK_W-1:0] thick_shadow = THICK_RESET;
  logic [RAD_W-1:0]   radius_shadow = RADIUS_RESET;

  logic [LEN_W-1:0] lengths_to_send[$];
  logic [ROT_W-1:0] rotations_due[$];
  int sender_idle_pct = 0;
  bit hold_sender = 1'b0;
  int cfg_writes = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_run = 0;
  int cycles = 0;

  // Integer square root, one result bit per step from the top.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0]  root;
    logic [31:0]  trial;
    logic [127:0] sq;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      sq = 128'(trial) * 128'(trial);
      if (sq <= 128'(v))
        root = trial;
    end
    return root;
  endfunction

  // Rotation in degrees Q24.8 for a length under the current register values.
  function automatic logic [ROT_W-1:0] predict_rotation(input logic [LEN_W-1:0] len_mm,
                                                        input logic [THICK_W-1:0] thick,
                                                        input logic [RAD_W-1:0] radius);
    logic [63:0]  len_um;
    logic [63:0]  tl;
    logic [127:0] prod;
    logic [63:0]  disc;
    logic [63:0]  root;
    logic [63:0]  quot;
    if (thick == '0)
      return '0;
    len_um = 64'(len_mm) * 64'd1000;
    tl = 64'(thick) * len_um;
    prod = 128'(tl) * 128'(INV_PI);
    // The discriminant in square micrometres with 14 fraction bits.
    disc = ((64'(radius) * 64'(radius)) << 14) + 64'(prod >> 18);
    root = 64'(floor_sqrt(disc));
    quot = ((root - (64'(radius) << 7)) * 64'd720) / 64'(thick);
    return (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
  endfunction

  // Driver: present the head of the queue at the falling edge, idling at random.
  always @(negedge clk) begin
    if (rst_n && !hold_sender && lengths_to_send.size() > 0 &&
        $urandom_range(99) >= sender_idle_pct) begin
      start <= 1'b1;
      in_length_mm <= lengths_to_send[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: takes accepted items, applies register writes and checks results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles,
               rotations_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n) begin
      if (start && !busy) begin
        rotations_due.push_back(predict_rotation(in_length_mm, thick_shadow, radius_shadow));
        void'(lengths_to_send.pop_front());
        items_sent <= items_sent + 1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THICK)
          thick_shadow <= cfg_data[THICK_W-1:0];
        else if (cfg_index == CFG_RADIUS)
          radius_shadow <= cfg_data[RAD_W-1:0];
        cfg_writes <= cfg_writes + 1;
      end
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (rotations_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Unexpected result %0d with nothing due", out_rotation_deg_q8);
        end else begin
          if (out_rotation_deg_q8 !== rotations_due[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("Rotation mismatch: expected %0d, got %0d", rotations_due[0],
                       out_rotation_deg_q8);
          end
          void'(rotations_due.pop_front());
        end
      end
    end
  end

  // A register write is only issued while nothing is in flight.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    while (cfg_writes == seen)
      @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits until every queued length has been sent and every due rotation has come back.
  task automatic drain;
    while (lengths_to_send.size() > 0 || rotations_due.size() > 0)
      @(negedge clk);
  endtask

  // Random lengths: half full range, a quarter short, a quarter near the top.
  function automatic logic [LEN_W-1:0] random_length();
    case ($urandom_range(3))
      0: return LEN_W'($urandom_range(255));
      1: return {LEN_W{1'b1}} - LEN_W'($urandom_range(255));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  logic [THICK_W-1:0] thick_set[8];
  logic [RAD_W-1:0]   radius_set[8];

  initial begin
    // Settings: extremes of both registers in every combination, one middle setting, then random ones.
    thick_set  = '{16'd1, 16'd65535, 16'd1, 16'd65535, 16'd250, 16'd0, 16'd0, 16'd0};
    radius_set = '{24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd12000, 24'd0, 24'd0, 24'd0};
    for (int i = 5; i < 8; i++) begin
      thick_set[i] = THICK_W'($urandom_range(65535, 1));
      radius_set[i] = RAD_W'($urandom_range(16777215, 1));
    end

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed lengths under the reset values: zero, one, all ones, 1000 and single bits.
    lengths_to_send.push_back('0);
    lengths_to_send.push_back(LEN_W'(1));
    lengths_to_send.push_back({LEN_W{1'b1}});
    lengths_to_send.push_back(LEN_W'(1000));
    for (int b = 0; b < LEN_W; b++)
      lengths_to_send.push_back(LEN_W'(1) << b);
    drain();

    // Random lengths for each setting, plus zero and all ones, with the idle rate at 8, 68 and then 0 percent.
    for (int s = 0; s < 8; s++) begin
      write_register(CFG_THICK, CFG_DATA_W'(thick_set[s]));
      write_register(CFG_RADIUS, radius_set[s]);
      sender_idle_pct = (s < 3) ? 8 : (s < 6) ? 68 : 0;
      lengths_to_send.push_back('0);
      lengths_to_send.push_back({LEN_W{1'b1}});
      for (int n = 0; n < 60; n++)
        lengths_to_send.push_back(random_length());
      // Halfway through the last setting the sender waits for the block to empty.
      if (s == 7) begin
        while (lengths_to_send.size() > 31)
          @(negedge clk);
        hold_sender = 1'b1;
        while (rotations_due.size() > 0)
          @(negedge clk);
        hold_sender = 1'b0;
      end
      drain();
      settings_run++;
    end

    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d lengths and checked %0d rotations over %0d register settings,",
             items_sent, results_seen, settings_run + 1);
    $display("including both register extremes and sender idle rates of 8, 68 and 0 percent.");
    if (mismatches == 0 && rotations_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d rotations never arrived", mismatches,
               rotations_due.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
